@@ rtl/msaw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msaw_pkg
// shared types, constants and the tap weight table for the smoothing block
// ----------------------------------------------------------------------------
package msaw_pkg;

   localparam int SampleBitsDefault = 16;
   localparam int TapCountDefault   = 15;
   localparam int AxisCountDefault  = 6;
   localparam int WindowLenDefault  = 900;
   localparam int TableLen          = 15;
   localparam int AvgBits           = 17;
   localparam int PeriodBits        = 16;
   localparam logic [PeriodBits-1:0] PeriodReset = 16'd900;
   localparam logic [AvgBits-1:0]    AvgMax      = 17'h1ffff;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] gyro_yaw;
      logic signed [15:0] gyro_pitch;
      logic signed [15:0] gyro_roll;
   } req_type;

   typedef struct packed {
      logic signed [15:0] smooth_x;
      logic signed [15:0] smooth_y;
      logic signed [15:0] smooth_z;
      logic signed [15:0] smooth_yaw;
      logic signed [15:0] smooth_pitch;
      logic signed [15:0] smooth_roll;
      logic [16:0]        activity_avg;
      logic               window_full;
      logic               analysis_mark;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FILT, ST_RING, ST_DIV, ST_OUT
   } state_type;

   // weight by sample age, age 0 is the newest sample; past the table weighs zero
   function automatic logic [15:0] tap_weight(input logic [4:0] age);
      logic [15:0] w;
      begin
         unique case (age)
            5'd0:  w = 16'd1099;
            5'd1:  w = 16'd1257;
            5'd2:  w = 16'd1425;
            5'd3:  w = 16'd1599;
            5'd4:  w = 16'd1776;
            5'd5:  w = 16'd1953;
            5'd6:  w = 16'd2126;
            5'd7:  w = 16'd2291;
            5'd8:  w = 16'd2445;
            5'd9:  w = 16'd2584;
            5'd10: w = 16'd2703;
            5'd11: w = 16'd2799;
            5'd12: w = 16'd2870;
            5'd13: w = 16'd2913;
            5'd14: w = 16'd2928;
            default: w = 16'd0;
         endcase
         return w;
      end
   endfunction

endpackage

@@ rtl/msaw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msaw_ram
// generic single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module msaw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

@@ rtl/msaw_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msaw_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module msaw_div #(
   parameter int NUM_BITS = 27,
   parameter int DEN_BITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic                done,
   output logic [NUM_BITS-1:0] quot
);
   localparam int CntBits = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] quot_ff, quot_in;
   logic [DEN_BITS:0]   rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [DEN_BITS+1:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         quot_in = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CntBits'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quot_ff[NUM_BITS-1]} - {2'b00, den_ff};
         if (!trial[DEN_BITS+1]) begin
            rem_in  = trial[DEN_BITS:0];
            quot_in = {quot_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[DEN_BITS-1:0], quot_ff[NUM_BITS-1]};
            quot_in = {quot_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

@@ rtl/motion_smoothing_activity_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_smoothing_activity_window
// six-axis gaussian smoothing with a windowed activity mean
// ----------------------------------------------------------------------------
// usage
//   req channel: one six-axis sample per beat, valid/ready
//   rsp channel: smoothed axes, activity mean, window full and analysis mark
//   csr port: write enable and data for analysis_period, written while idle
// schedule
//   one sample at a time; each tap is read, then multiplied, accumulated and
//   written back one slot along, and each axis ends with a rounding step;
//   all of this runs on one shared 16x16 multiplier and one history ram
//   port; then the ring is read and written, the serial divider runs and
//   the output register is loaded; the history port and the divider set the
//   pace of accepted samples
// reset
//   synchronous, active high; history ram is zeroed by a clearing pass over
//   all AXIS_COUNT*TAP_COUNT entries, during which req_ready stays low
// stall
//   the result sits in the output register until rsp_ready; the next sample
//   is accepted and filtered meanwhile and its result waits until that beat
//   has gone
// ----------------------------------------------------------------------------
module motion_smoothing_activity_window
   import msaw_pkg::*;
#(
   parameter int WINDOW_LEN  = WindowLenDefault,
   parameter int TAP_COUNT   = TapCountDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [PeriodBits-1:0] csr_wr_data
);
   // axis count and sample width are fixed by the payload structs
   localparam int AXIS_COUNT  = AxisCountDefault;
   localparam int SAMPLE_BITS = SampleBitsDefault;
   localparam int HistDepth = AXIS_COUNT * TAP_COUNT;
   localparam int HistAbits = $clog2(HistDepth);
   localparam int TapBits   = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
   localparam int AxBits    = $clog2(AXIS_COUNT);
   localparam int RingAbits = $clog2(WINDOW_LEN);
   localparam int FillBits  = $clog2(WINDOW_LEN + 1);
   localparam int TotBits   = AvgBits + FillBits;
   localparam int AccBits   = SAMPLE_BITS + 16 + 5;
   localparam int QBits     = AccBits - 15;

   state_type state_ff, state_in;

   // counters and registers
   logic [HistAbits-1:0]  clr_ff, clr_in;
   logic                  clr_busy_ff, clr_busy_in;
   logic [AxBits-1:0]     ax_ff, ax_in;
   logic [TapBits-1:0]    tap_ff, tap_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [TapBits-1:0]    rd_tap_ff, rd_tap_in;
   logic [SAMPLE_BITS-1:0] carry_ff, carry_in;
   logic signed [AccBits-1:0] acc_ff, acc_in;
   logic                  fin_ff, fin_in;
   req_type               req_ff, req_in;
   logic [AXIS_COUNT-1:0][15:0] sm_ff, sm_in;
   logic [AvgBits-1:0]    act_ff, act_in;
   logic [RingAbits-1:0]  ptr_ff, ptr_in;
   logic [FillBits-1:0]   fill_ff, fill_in;
   logic [TotBits-1:0]    tot_ff, tot_in;
   logic [PeriodBits-1:0] pcnt_ff, pcnt_in, per_ff, per_in;
   logic                  mark_ff, mark_in, rv_ff, rv_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  ring_ph_ff, ring_ph_in;

   // memory ports
   logic                   h_we, r_we, div_start, div_done;
   logic [HistAbits-1:0]   h_addr;
   logic [SAMPLE_BITS-1:0] h_wd, h_rd;
   logic [AvgBits-1:0]     r_rd;
   logic [TotBits-1:0]     div_num, div_q;
   logic signed [SAMPLE_BITS-1:0] cur;
   logic signed [SAMPLE_BITS+16:0] prod;
   logic signed [QBits-1:0] q;
   logic [15:0]            qs;
   logic [SAMPLE_BITS-1:0] in_ax;
   logic [TotBits-1:0]     tot_sub;
   logic [PeriodBits-1:0]  pinc;

   msaw_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HistDepth)) u_hist (
      .clock(clock), .wr_en(h_we), .addr(h_addr), .wr_data(h_wd), .rd_data(h_rd));

   msaw_ram #(.WIDTH(AvgBits), .DEPTH(WINDOW_LEN)) u_ring (
      .clock(clock), .wr_en(r_we), .addr(ptr_ff), .wr_data(act_ff), .rd_data(r_rd));

   msaw_div #(.NUM_BITS(TotBits), .DEN_BITS(FillBits)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(fill_ff), .done(div_done), .quot(div_q));

   // input axis picked by the axis counter
   always_comb begin
      unique case (ax_ff)
         AxBits'(0): in_ax = SAMPLE_BITS'(req_ff.accel_x);
         AxBits'(1): in_ax = SAMPLE_BITS'(req_ff.accel_y);
         AxBits'(2): in_ax = SAMPLE_BITS'(req_ff.accel_z);
         AxBits'(3): in_ax = SAMPLE_BITS'(req_ff.gyro_yaw);
         AxBits'(4): in_ax = SAMPLE_BITS'(req_ff.gyro_pitch);
         default:    in_ax = SAMPLE_BITS'(req_ff.gyro_roll);
      endcase
   end

   // rounding and saturation of the finished accumulator
   always_comb begin
      q = QBits'((acc_ff + AccBits'(16384)) >>> 15);
      if (q > QBits'(32767))       qs = 16'h7fff;
      else if (q < -QBits'(32768)) qs = 16'h8000;
      else                          qs = q[15:0];
   end

   assign pinc = pcnt_ff + 1'b1;

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      clr_busy_in = clr_busy_ff;
      ax_in       = ax_ff;
      tap_in      = tap_ff;
      rd_vld_in   = 1'b0;
      rd_tap_in   = tap_ff;
      carry_in    = carry_ff;
      acc_in      = acc_ff;
      fin_in      = 1'b0;
      req_in      = req_ff;
      sm_in       = sm_ff;
      act_in      = act_ff;
      ptr_in      = ptr_ff;
      fill_in     = fill_ff;
      tot_in      = tot_ff;
      pcnt_in     = pcnt_ff;
      per_in      = csr_wr_en ? csr_wr_data : per_ff;
      mark_in     = mark_ff;
      rv_in       = rv_ff;
      rsp_in      = rsp_ff;
      ring_ph_in  = ring_ph_ff;
      h_we        = 1'b0;
      h_addr      = HistAbits'(ax_ff * TAP_COUNT + tap_ff);
      h_wd        = '0;
      r_we        = 1'b0;
      div_start   = 1'b0;
      div_num     = tot_ff;
      req_ready   = 1'b0;
      cur         = '0;
      prod        = '0;
      tot_sub     = tot_ff;

      if (rv_ff && rsp_ready) rv_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (clr_busy_ff) begin
               h_we   = 1'b1;
               h_addr = clr_ff;
               clr_in = clr_ff + 1'b1;
               if (clr_ff == HistAbits'(HistDepth - 1)) clr_busy_in = 1'b0;
            end else begin
               req_ready = 1'b1;
               if (req_valid) begin
                  req_in   = req_data;
                  ax_in    = '0;
                  tap_in   = '0;
                  acc_in   = '0;
                  state_in = ST_FILT;
               end
            end
         end
         ST_FILT: begin
            // read tap, then shift it along one slot while the mac uses it
            if (rd_vld_ff) begin
               cur  = (rd_tap_ff == '0) ? $signed(in_ax) : $signed(carry_ff);
               prod = cur * $signed({1'b0, tap_weight(5'(rd_tap_ff))});
               acc_in   = acc_ff + AccBits'(prod);
               carry_in = h_rd;
               h_we     = 1'b1;
               h_addr   = HistAbits'(ax_ff * TAP_COUNT + rd_tap_ff);
               h_wd     = cur;
               if (rd_tap_ff == TapBits'(TAP_COUNT - 1)) fin_in = 1'b1;
            end else if (!fin_ff) begin
               rd_vld_in = 1'b1;
               tap_in    = tap_ff + 1'b1;
            end
            if (fin_ff) begin
               sm_in[ax_ff] = qs;
               if (ax_ff < AxBits'(3))
                  act_in = (ax_ff == '0 ? '0 : act_ff) +
                     AvgBits'(qs[15] ? 16'(-qs) : qs);
               acc_in = '0;
               tap_in = '0;
               if (ax_ff == AxBits'(AXIS_COUNT - 1)) begin
                  state_in   = ST_RING;
                  ring_ph_in = 1'b0;
               end else begin
                  ax_in = ax_ff + 1'b1;
               end
            end
         end
         ST_RING: begin
            // first phase reads the oldest entry, second writes the new one
            if (!ring_ph_ff) begin
               ring_ph_in = 1'b1;
            end else begin
               if (fill_ff == FillBits'(WINDOW_LEN)) tot_sub = tot_ff - TotBits'(r_rd);
               else fill_in = fill_ff + 1'b1;
               tot_in = tot_sub + TotBits'(act_ff);
               r_we   = 1'b1;
               ptr_in = (ptr_ff == RingAbits'(WINDOW_LEN - 1)) ? '0 : ptr_ff + 1'b1;
               mark_in = (pinc == per_ff);
               pcnt_in = (pinc == per_ff) ? '0 : pinc;
               state_in = ST_DIV;
               ring_ph_in = 1'b0;
            end
         end
         ST_DIV: begin
            if (!ring_ph_ff) begin
               div_start  = 1'b1;
               div_num    = tot_ff + TotBits'(fill_ff >> 1);
               ring_ph_in = 1'b1;
            end else if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // wait here while the previous beat still holds the output register
            if (!rv_ff || rsp_ready) begin
               rsp_in.smooth_x      = sm_ff[0];
               rsp_in.smooth_y      = sm_ff[1];
               rsp_in.smooth_z      = sm_ff[2];
               rsp_in.smooth_yaw    = sm_ff[3];
               rsp_in.smooth_pitch  = sm_ff[4];
               rsp_in.smooth_roll   = sm_ff[5];
               rsp_in.activity_avg  = (div_q > TotBits'(AvgMax)) ? AvgMax : div_q[AvgBits-1:0];
               rsp_in.window_full   = (fill_ff == FillBits'(WINDOW_LEN));
               rsp_in.analysis_mark = mark_ff;
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         clr_ff      <= '0;
         clr_busy_ff <= 1'b1;
         rd_vld_ff   <= 1'b0;
         fin_ff      <= 1'b0;
         ax_ff       <= '0;
         tap_ff      <= '0;
         ptr_ff      <= '0;
         fill_ff     <= '0;
         tot_ff      <= '0;
         pcnt_ff     <= '0;
         per_ff      <= PeriodReset;
         rv_ff       <= 1'b0;
         ring_ph_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         clr_busy_ff <= clr_busy_in;
         rd_vld_ff   <= rd_vld_in;
         fin_ff      <= fin_in;
         ax_ff       <= ax_in;
         tap_ff      <= tap_in;
         ptr_ff      <= ptr_in;
         fill_ff     <= fill_in;
         tot_ff      <= tot_in;
         pcnt_ff     <= pcnt_in;
         per_ff      <= per_in;
         rv_ff       <= rv_in;
         ring_ph_ff  <= ring_ph_in;
      end
      rd_tap_ff <= rd_tap_in;
      carry_ff  <= carry_in;
      acc_ff    <= acc_in;
      req_ff    <= req_in;
      sm_ff     <= sm_in;
      act_ff    <= act_in;
      mark_ff   <= mark_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillBits'(WINDOW_LEN)) else $error("fill count overrun");
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff < RingAbits'(WINDOW_LEN)) else $error("ring pointer out of range");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == ST_IDLE && !clr_busy_ff))
      else $error("accept while busy");
   a_rsp_after_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(state_ff) == ST_OUT) else $error("stray result");
`endif
endmodule

@@ tb/sv/motion_smoothing_activity_window_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_smoothing_activity_window_tb
// self-checking bench for the six-axis smoothing and activity window block
// ----------------------------------------------------------------------------
// samples are driven on the req channel. A scoreboard class works out the
// smoothed axes, the window mean, the window full flag and the analysis mark.
// It compares each rsp beat, field by field, with the oldest outstanding
// prediction. Both channels idle at random. The analysis period register is
// reprogrammed between phases, and only while the block is idle.
// ----------------------------------------------------------------------------
module motion_smoothing_activity_window_tb;
   import msaw_pkg::*;

   localparam int WinLen  = 900;
   localparam int Taps    = 15;
   localparam int NumAxes = 6;

   // ---------------------------------------------------------------------------
   // predictor and store of expected beats
   // ---------------------------------------------------------------------------
   class smoothing_scoreboard;
      logic signed [15:0] hist [NumAxes][Taps];
      logic [16:0]        ring [WinLen];
      int unsigned        ring_ptr;
      int unsigned        fill;
      longint unsigned    total;
      logic [15:0]        period_cnt;
      logic [15:0]        period;
      rsp_type            pending [$];
      int                 mismatches;

      function new();
         ring_ptr   = 0;
         fill       = 0;
         total      = 0;
         period_cnt = '0;
         period     = PeriodReset;
         mismatches = 0;
         foreach (hist[a, j]) hist[a][j] = '0;
      endfunction

      function void set_period(logic [15:0] p);
         period = p;
      endfunction

      // fir over the history, age 0 newest, rounded half up, saturated
      function logic signed [15:0] fir_axis(int a);
         longint acc;
         longint q;
         acc = 0;
         for (int j = 0; j < Taps; j++) begin
            acc += longint'(hist[a][j]) * longint'(tap_weight(5'(j)));
         end
         q = (acc + 16384) >>> 15;
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         return 16'(q);
      endfunction

      function void note_sample(req_type s);
         rsp_type           r;
         logic signed [15:0] ins [NumAxes];
         logic signed [15:0] sm  [NumAxes];
         longint unsigned   act;
         longint unsigned   avg;
         ins = '{s.accel_x, s.accel_y, s.accel_z, s.gyro_yaw, s.gyro_pitch, s.gyro_roll};
         act = 0;
         for (int a = 0; a < NumAxes; a++) begin
            for (int j = Taps - 1; j > 0; j--) hist[a][j] = hist[a][j-1];
            hist[a][0] = ins[a];
            sm[a] = fir_axis(a);
            if (a < 3) act += (sm[a] < 0) ? longint'(-int'(sm[a])) : longint'(sm[a]);
         end
         if (fill >= WinLen) total -= ring[ring_ptr];
         else fill++;
         total += act;
         ring[ring_ptr] = 17'(act);
         ring_ptr = (ring_ptr + 1 >= WinLen) ? 0 : ring_ptr + 1;
         avg = (total + (fill >> 1)) / fill;
         if (avg > 131071) avg = 131071;
         period_cnt = period_cnt + 16'd1;
         r.analysis_mark = (period_cnt == period);
         if (r.analysis_mark) period_cnt = '0;
         r.smooth_x     = sm[0];
         r.smooth_y     = sm[1];
         r.smooth_z     = sm[2];
         r.smooth_yaw   = sm[3];
         r.smooth_pitch = sm[4];
         r.smooth_roll  = sm[5];
         r.activity_avg = 17'(avg);
         r.window_full  = (fill >= WinLen);
         pending.push_back(r);
      endfunction

      function void report(string f, longint e, longint g);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d", f, e, g);
      endfunction

      function void check_beat(rsp_type g);
         rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp beat %h", g);
            return;
         end
         e = pending.pop_front();
         if (g.smooth_x !== e.smooth_x) report("smooth_x", e.smooth_x, g.smooth_x);
         if (g.smooth_y !== e.smooth_y) report("smooth_y", e.smooth_y, g.smooth_y);
         if (g.smooth_z !== e.smooth_z) report("smooth_z", e.smooth_z, g.smooth_z);
         if (g.smooth_yaw !== e.smooth_yaw)
            report("smooth_yaw", e.smooth_yaw, g.smooth_yaw);
         if (g.smooth_pitch !== e.smooth_pitch)
            report("smooth_pitch", e.smooth_pitch, g.smooth_pitch);
         if (g.smooth_roll !== e.smooth_roll)
            report("smooth_roll", e.smooth_roll, g.smooth_roll);
         if (g.activity_avg !== e.activity_avg)
            report("activity_avg", e.activity_avg, g.activity_avg);
         if (g.window_full !== e.window_full)
            report("window_full", e.window_full, g.window_full);
         if (g.analysis_mark !== e.analysis_mark)
            report("analysis_mark", e.analysis_mark, g.analysis_mark);
      endfunction
   endclass

   // ---------------------------------------------------------------------------
   // block hookup
   // ---------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   smoothing_scoreboard sb;
   bit  calm_stretch;   // no idling on either side while set

   motion_smoothing_activity_window u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // generous limit: covers every beat with its stalls, and the clearing pass
   initial begin
      #(12 * 3000000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // rsp side: random stalls, check on each accepted beat
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_beat(rsp_data);
      rsp_ready <= calm_stretch || ($urandom_range(99) >= 28);
   end

   // ---------------------------------------------------------------------------
   // stimulus tasks
   // ---------------------------------------------------------------------------
   // send one sample, idle gaps first, then hold valid until accepted
   task automatic send_sample(req_type s);
      while (!calm_stretch && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(s);
   endtask

   // wait until every beat has come back, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_period(logic [15:0] p);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= p;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_period(p);
   endtask

   function automatic logic [15:0] rand_axis(int style);
      case (style)
         0: return 16'($urandom);
         1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
         2: return 16'($signed($urandom_range(600)) - 300);
         default: return 16'(32767 - $urandom_range(64));
      endcase
   endfunction

   task automatic random_samples(int n);
      req_type s;
      int      style;
      for (int i = 0; i < n; i++) begin
         style = $urandom_range(3);
         s.accel_x    = rand_axis(style);
         s.accel_y    = rand_axis(style);
         s.accel_z    = rand_axis(style);
         s.gyro_yaw   = rand_axis(style);
         s.gyro_pitch = rand_axis(style);
         s.gyro_roll  = rand_axis(style);
         send_sample(s);
      end
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      req_type s;
      sb = new();
      calm_stretch = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: period 1 marks every beat, then saturating extremes
      write_period(16'd1);
      s = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
      repeat (16) send_sample(s);
      s = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
      repeat (4) send_sample(s);
      s = '{16'h0000, 16'hffff, 16'h0001, 16'h8000, 16'h7fff, 16'h5555};
      repeat (3) send_sample(s);
      drain();

      // period 0: marks only every 65536th beat
      write_period(16'd0);
      random_samples(300);
      // stretch with no idling on either side
      calm_stretch = 1'b1;
      random_samples(250);
      calm_stretch = 1'b0;
      drain();

      // period 7, then lowered to 3
      write_period(16'd7);
      random_samples(400);
      drain();
      write_period(16'd3);
      random_samples(300);
      drain();

      // top of the range, then back to the reset value
      write_period(16'hffff);
      random_samples(250);
      drain();
      write_period(16'd900);
      random_samples(250);
      drain();

      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
